// ===== design/interval_set_merge_table_macros.svh =====
// Assertion macros used by the datapath (ismt_dp)
`ifndef INTERVAL_SET_MERGE_TABLE_MACROS_SVH
`define INTERVAL_SET_MERGE_TABLE_MACROS_SVH

// Check that an expression holds on every clock edge outside reset
`define ISMT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ISMT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/ismt_pkg.sv =====
package ismt_pkg;

    localparam int DEF_ENTRIES     = 64;
    localparam int DEF_POS_BITS    = 32;
    localparam int DEF_CONTIG_BITS = 8;
    localparam int GAP_W           = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [1:0] OP_SCAN    = 2'd0;
    localparam logic [1:0] OP_COMPACT = 2'd1;
    localparam logic [1:0] OP_FILL    = 2'd2;
    localparam logic [1:0] OP_SHIFT   = 2'd3;

    localparam logic [1:0] RK_INSERT   = 2'd0;
    localparam logic [1:0] RK_EMPTY    = 2'd1;
    localparam logic [1:0] RK_OVERFLOW = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       init;
        logic       run;
        logic [1:0] op;
        logic       place;
        logic       resp_load;
        logic [1:0] resp_kind;
        logic       dump_rd;
        logic       dump_load;
    } ismt_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic absorbed;
        logic full;
        logic empty;
        logic out_free;
        logic dump_last;
    } ismt_stat_t;

endpackage

// ===== design/ismt_ctrl.sv =====
module ismt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic [1:0]         in_cmd,
    input  ismt_pkg::ismt_stat_t stat,
    output ismt_pkg::ismt_cmd_t  cmd,
    output logic               in_ready
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_CHECK     = 4'd2;
    localparam logic [3:0] S_COMPACT   = 4'd3;
    localparam logic [3:0] S_PREP      = 4'd4;
    localparam logic [3:0] S_SHIFT     = 4'd5;
    localparam logic [3:0] S_PLACE     = 4'd6;
    localparam logic [3:0] S_FILL      = 4'd7;
    localparam logic [3:0] S_RESP_INS  = 4'd8;
    localparam logic [3:0] S_RESP_NONE = 4'd9;
    localparam logic [3:0] S_RESP_OVF  = 4'd10;
    localparam logic [3:0] S_DUMP_RD   = 4'd11;
    localparam logic [3:0] S_DUMP_WT   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.latch = 1'b1;
                    unique case (in_cmd)
                        ismt_pkg::CMD_INSERT:
                        begin
                            cmd.init   = 1'b1;
                            state_next = S_SCAN;
                        end
                        ismt_pkg::CMD_FILL:
                        begin
                            cmd.init   = 1'b1;
                            state_next = S_FILL;
                        end
                        ismt_pkg::CMD_DUMP:
                        begin
                            cmd.init = 1'b1;
                            if (stat.empty)
                                state_next = S_RESP_NONE;
                            else
                                state_next = S_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.run = 1'b1;
                cmd.op  = ismt_pkg::OP_SCAN;
                if (stat.pass_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.absorbed && stat.full)
                    state_next = S_RESP_OVF;
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = S_COMPACT;
                end
            end
            S_COMPACT:
            begin
                cmd.run = 1'b1;
                cmd.op  = ismt_pkg::OP_COMPACT;
                if (stat.pass_done)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.init   = 1'b1;
                cmd.op     = ismt_pkg::OP_SHIFT;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.run = 1'b1;
                cmd.op  = ismt_pkg::OP_SHIFT;
                if (stat.pass_done)
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_RESP_INS;
            end
            S_FILL:
            begin
                cmd.run = 1'b1;
                cmd.op  = ismt_pkg::OP_FILL;
                if (stat.pass_done)
                    state_next = S_RESP_NONE;
            end
            S_RESP_INS, S_RESP_NONE, S_RESP_OVF:
            begin
                if (stat.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    if (state_reg == S_RESP_INS)
                        cmd.resp_kind = ismt_pkg::RK_INSERT;
                    else if (state_reg == S_RESP_OVF)
                        cmd.resp_kind = ismt_pkg::RK_OVERFLOW;
                    else
                        cmd.resp_kind = ismt_pkg::RK_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                cmd.dump_rd = 1'b1;
                state_next  = S_DUMP_WT;
            end
            S_DUMP_WT:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_load = 1'b1;
                    if (stat.dump_last)
                        state_next = S_IDLE;
                    else
                        state_next = S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/ismt_dp.sv =====
`include "interval_set_merge_table_macros.svh"

module ismt_dp
#(
    parameter int ENTRIES     = ismt_pkg::DEF_ENTRIES,
    parameter int POS_BITS    = ismt_pkg::DEF_POS_BITS,
    parameter int CONTIG_BITS = ismt_pkg::DEF_CONTIG_BITS,
    parameter int CNT_W       = $clog2(ENTRIES + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ismt_pkg::ismt_cmd_t         cmd,
    output ismt_pkg::ismt_stat_t        stat,
    input  logic [CONTIG_BITS-1:0]      in_contig,
    input  logic [POS_BITS-1:0]         in_start,
    input  logic [POS_BITS-1:0]         in_end,
    input  logic                        cfg_wr_en,
    input  logic [ismt_pkg::GAP_W-1:0]  cfg_wr_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [CONTIG_BITS-1:0]      out_contig,
    output logic [POS_BITS-1:0]         out_start,
    output logic [POS_BITS-1:0]         out_end,
    output logic                        out_entry_valid,
    output logic [CNT_W-1:0]            out_count,
    output logic                        out_overflow,
    output logic                        out_last
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SUM_W = ((POS_BITS > ismt_pkg::GAP_W) ? POS_BITS : ismt_pkg::GAP_W) + 1;

    logic [CONTIG_BITS-1:0] mem_contig [ENTRIES];
    logic [POS_BITS-1:0]    mem_start  [ENTRIES];
    logic [POS_BITS-1:0]    mem_end    [ENTRIES];

    logic [CONTIG_BITS-1:0] q_contig_reg;
    logic [POS_BITS-1:0]    q_start_reg;
    logic [POS_BITS-1:0]    q_end_reg;

    logic [CONTIG_BITS-1:0] cur_contig_reg;
    logic [POS_BITS-1:0]    cur_start_reg;
    logic [POS_BITS-1:0]    cur_end_reg;
    logic [POS_BITS-1:0]    lo_reg;
    logic [POS_BITS-1:0]    hi_reg;
    logic [CONTIG_BITS-1:0] last_contig_reg;
    logic [POS_BITS-1:0]    last_start_reg;
    logic [POS_BITS-1:0]    last_end_reg;

    logic                        absorbed_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [ismt_pkg::GAP_W-1:0]  gap_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            pidx_reg;
    logic                        pv_reg;
    logic [CNT_W-1:0]            w_reg;
    logic                        has_last_reg;
    logic                        stop_reg;
    logic [AW-1:0]               ins_pos_reg;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [CNT_W-1:0]       idx_m1;
    logic [CNT_W-1:0]       pidx_p1;
    logic [CNT_W-1:0]       w_m1;
    logic                   fwd_issue;
    logic                   shift_issue;
    logic                   is_shift;
    logic                   match;
    logic                   after;
    logic                   bridge;
    logic [SUM_W-1:0]       reach;
    logic [POS_BITS-1:0]    merge_start;
    logic [POS_BITS-1:0]    merge_end;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [CONTIG_BITS-1:0] wr_contig;
    logic [POS_BITS-1:0]    wr_start;
    logic [POS_BITS-1:0]    wr_end;
    logic                   proc;
    logic                   pack_pass;
    logic [POS_BITS-1:0]    in_end_fix;

    assign is_shift    = (cmd.op == ismt_pkg::OP_SHIFT);
    assign idx_m1      = idx_reg - 1'b1;
    assign pidx_p1     = pidx_reg + 1'b1;
    assign w_m1        = w_reg - 1'b1;
    assign fwd_issue   = cmd.run && !is_shift && (idx_reg < count_reg);
    assign shift_issue = cmd.run && is_shift && (idx_reg != '0) && !stop_reg;
    assign rd_en       = fwd_issue || shift_issue || cmd.dump_rd;
    assign rd_addr     = is_shift ? idx_m1[AW-1:0] : idx_reg[AW-1:0];
    assign proc        = cmd.run && pv_reg;
    assign pack_pass   = proc && (cmd.op == ismt_pkg::OP_COMPACT || cmd.op == ismt_pkg::OP_FILL);
    assign in_end_fix  = (in_end < in_start) ? in_start : in_end;

    assign match = (q_contig_reg == cur_contig_reg) && (q_start_reg <= cur_end_reg)
                   && (cur_start_reg <= q_end_reg);

    always_comb
    begin
        if (q_contig_reg != cur_contig_reg)
            after = (q_contig_reg > cur_contig_reg);
        else if (q_start_reg != lo_reg)
            after = (q_start_reg > lo_reg);
        else
            after = (q_end_reg > hi_reg);
    end

    assign reach       = SUM_W'(last_end_reg) + SUM_W'(gap_reg);
    assign bridge      = has_last_reg && (last_contig_reg == q_contig_reg)
                         && (SUM_W'(q_start_reg) <= reach);
    assign merge_start = (q_start_reg < last_start_reg) ? q_start_reg : last_start_reg;
    assign merge_end   = (q_end_reg > last_end_reg) ? q_end_reg : last_end_reg;

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = w_reg[AW-1:0];
        wr_contig = q_contig_reg;
        wr_start  = q_start_reg;
        wr_end    = q_end_reg;
        if (cmd.place)
        begin
            wr_en     = 1'b1;
            wr_addr   = ins_pos_reg;
            wr_contig = cur_contig_reg;
            wr_start  = lo_reg;
            wr_end    = hi_reg;
        end
        else if (proc)
        begin
            unique case (cmd.op)
                ismt_pkg::OP_SCAN:
                begin
                    wr_en = 1'b0;
                end
                ismt_pkg::OP_COMPACT:
                begin
                    wr_en = !match;
                end
                ismt_pkg::OP_FILL:
                begin
                    wr_en = 1'b1;
                    if (bridge)
                    begin
                        wr_addr  = w_m1[AW-1:0];
                        wr_start = merge_start;
                        wr_end   = merge_end;
                    end
                end
                ismt_pkg::OP_SHIFT:
                begin
                    wr_en   = !stop_reg && after;
                    wr_addr = pidx_p1[AW-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_contig[wr_addr] <= wr_contig;
            mem_start[wr_addr]  <= wr_start;
            mem_end[wr_addr]    <= wr_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_contig_reg <= mem_contig[rd_addr];
            q_start_reg  <= mem_start[rd_addr];
            q_end_reg    <= mem_end[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cur_contig_reg <= in_contig;
            cur_start_reg  <= in_start;
            cur_end_reg    <= in_end_fix;
            lo_reg         <= in_start;
            hi_reg         <= in_end_fix;
        end
        else if (proc && (cmd.op == ismt_pkg::OP_SCAN) && match)
        begin
            if (q_start_reg < lo_reg)
                lo_reg <= q_start_reg;
            if (q_end_reg > hi_reg)
                hi_reg <= q_end_reg;
        end
        if (proc && (cmd.op == ismt_pkg::OP_FILL))
        begin
            if (bridge)
            begin
                last_start_reg <= merge_start;
                last_end_reg   <= merge_end;
            end
            else
            begin
                last_contig_reg <= q_contig_reg;
                last_start_reg  <= q_start_reg;
                last_end_reg    <= q_end_reg;
            end
        end
    end

    always_comb
    begin
        stat.absorbed  = absorbed_reg;
        stat.full      = (count_reg == CNT_W'(ENTRIES));
        stat.empty     = (count_reg == '0);
        stat.out_free  = !out_valid || out_ready;
        stat.dump_last = (idx_reg == CNT_W'(count_reg - 1'b1));
        if (is_shift)
            stat.pass_done = stop_reg || ((idx_reg == '0) && !pv_reg);
        else
            stat.pass_done = (idx_reg >= count_reg) && !pv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            absorbed_reg <= 1'b0;
            count_reg    <= '0;
            gap_reg      <= '0;
            idx_reg      <= '0;
            pidx_reg     <= '0;
            pv_reg       <= 1'b0;
            w_reg        <= '0;
            has_last_reg <= 1'b0;
            stop_reg     <= 1'b0;
            ins_pos_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                gap_reg <= cfg_wr_data;
            if (cmd.latch)
                absorbed_reg <= 1'b0;
            if (cmd.init)
            begin
                idx_reg      <= is_shift ? count_reg : '0;
                pv_reg       <= 1'b0;
                w_reg        <= '0;
                has_last_reg <= 1'b0;
                stop_reg     <= 1'b0;
                ins_pos_reg  <= '0;
            end
            else if (cmd.run)
            begin
                pv_reg <= fwd_issue || shift_issue;
                if (fwd_issue)
                begin
                    idx_reg  <= idx_reg + 1'b1;
                    pidx_reg <= idx_reg;
                end
                else if (shift_issue)
                begin
                    idx_reg  <= idx_m1;
                    pidx_reg <= idx_m1;
                end
                if (pv_reg)
                begin
                    unique case (cmd.op)
                        ismt_pkg::OP_SCAN:
                        begin
                            if (match)
                                absorbed_reg <= 1'b1;
                        end
                        ismt_pkg::OP_COMPACT:
                        begin
                            if (!match)
                                w_reg <= w_reg + 1'b1;
                        end
                        ismt_pkg::OP_FILL:
                        begin
                            if (!bridge)
                            begin
                                w_reg        <= w_reg + 1'b1;
                                has_last_reg <= 1'b1;
                            end
                        end
                        ismt_pkg::OP_SHIFT:
                        begin
                            if (!stop_reg && !after)
                            begin
                                stop_reg    <= 1'b1;
                                ins_pos_reg <= pidx_p1[AW-1:0];
                            end
                        end
                    endcase
                end
                if (stat.pass_done && !is_shift && (cmd.op != ismt_pkg::OP_SCAN))
                    count_reg <= w_reg;
            end
            if (cmd.place)
                count_reg <= count_reg + 1'b1;
            if (cmd.dump_load)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.resp_load || cmd.dump_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            out_count    <= count_reg;
            out_last     <= 1'b1;
            out_overflow <= (cmd.resp_kind == ismt_pkg::RK_OVERFLOW);
            if (cmd.resp_kind == ismt_pkg::RK_INSERT)
            begin
                out_contig      <= cur_contig_reg;
                out_start       <= lo_reg;
                out_end         <= hi_reg;
                out_entry_valid <= 1'b1;
            end
            else
            begin
                out_contig      <= '0;
                out_start       <= '0;
                out_end         <= '0;
                out_entry_valid <= 1'b0;
            end
        end
        else if (cmd.dump_load)
        begin
            out_count       <= count_reg;
            out_last        <= stat.dump_last;
            out_overflow    <= 1'b0;
            out_contig      <= q_contig_reg;
            out_start       <= q_start_reg;
            out_end         <= q_end_reg;
            out_entry_valid <= 1'b1;
        end
    end

    `ISMT_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(ENTRIES), "count above depth")
    `ISMT_ASSERT_IMPLY(a_compact_order, pack_pass, w_reg <= pidx_reg, "write passed read")
    `ISMT_ASSERT_IMPLY(a_load_free, cmd.resp_load || cmd.dump_load, stat.out_free, "result lost")
    `ISMT_ASSERT_IMPLY(a_place_room, cmd.place, count_reg < CNT_W'(ENTRIES), "place into full table")

endmodule

// ===== design/interval_set_merge_table.sv =====
// Insert: scan, compact and shift passes over the table memory (one read and one write
// port), one entry per cycle each, then a place; a full table with no overlap ends after the
// scan with overflow. Fill: one merge pass. Dump: one entry per beat. One item in work at a time.
// Reset clears the entry count and fill gap; table contents are not cleared.
module interval_set_merge_table
#(
    parameter int ENTRIES     = ismt_pkg::DEF_ENTRIES,
    parameter int POS_BITS    = ismt_pkg::DEF_POS_BITS,
    parameter int CONTIG_BITS = ismt_pkg::DEF_CONTIG_BITS,
    parameter int CNT_W       = $clog2(ENTRIES + 1),
    parameter int IN_TW       = ((CONTIG_BITS + 2 * POS_BITS + 7) / 8) * 8,
    parameter int OUT_TW      = ((CONTIG_BITS + 2 * POS_BITS + CNT_W + 7) / 8) * 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TW-1:0]           s_axis_tdata,  // region_contig, region_start, region_end
    input  logic [1:0]                 s_axis_tuser,  // cmd
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TW-1:0]          m_axis_tdata,  // out_contig, out_start, out_end, entry_count
    output logic [1:0]                 m_axis_tuser,  // entry_valid, overflow
    output logic                       m_axis_tlast,
    input  logic                       cfg_wr_en,
    input  logic [ismt_pkg::GAP_W-1:0] cfg_wr_data
);

    ismt_pkg::ismt_cmd_t  cmd;
    ismt_pkg::ismt_stat_t stat;

    logic                   in_accept;
    logic [CONTIG_BITS-1:0] out_contig;
    logic [POS_BITS-1:0]    out_start;
    logic [POS_BITS-1:0]    out_end;
    logic                   out_entry_valid;
    logic [CNT_W-1:0]       out_count;
    logic                   out_overflow;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    ismt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_cmd    (s_axis_tuser),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_axis_tready)
    );

    ismt_dp
    #(
        .ENTRIES     (ENTRIES),
        .POS_BITS    (POS_BITS),
        .CONTIG_BITS (CONTIG_BITS),
        .CNT_W       (CNT_W)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_contig       (s_axis_tdata[CONTIG_BITS-1:0]),
        .in_start        (s_axis_tdata[CONTIG_BITS+POS_BITS-1:CONTIG_BITS]),
        .in_end          (s_axis_tdata[CONTIG_BITS+2*POS_BITS-1:CONTIG_BITS+POS_BITS]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_contig      (out_contig),
        .out_start       (out_start),
        .out_end         (out_end),
        .out_entry_valid (out_entry_valid),
        .out_count       (out_count),
        .out_overflow    (out_overflow),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TW'({out_count, out_end, out_start, out_contig});
    assign m_axis_tuser = {out_overflow, out_entry_valid};

endmodule
